// File: rtl/v3n_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package v3n_pkg;

    localparam int FIELD_BITS = 32;
    localparam int UNIT_FRAC  = 30;
    // quotient never exceeds 1.0, so one bit above the fraction is enough
    localparam int QUOT_BITS  = UNIT_FRAC + 1;

endpackage

`default_nettype wire

// File: rtl/v3n_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface v3n_vec_if import v3n_pkg::*;;
    logic                          valid;
    logic                          ready;
    logic signed [FIELD_BITS-1:0]  vec_x;
    logic signed [FIELD_BITS-1:0]  vec_y;
    logic signed [FIELD_BITS-1:0]  vec_z;

    modport source (output valid, vec_x, vec_y, vec_z, input ready);
    modport sink   (input valid, vec_x, vec_y, vec_z, output ready);
endinterface

interface v3n_res_if import v3n_pkg::*;;
    logic                          valid;
    logic                          ready;
    logic signed [FIELD_BITS-1:0]  unit_x;
    logic signed [FIELD_BITS-1:0]  unit_y;
    logic signed [FIELD_BITS-1:0]  unit_z;
    logic        [FIELD_BITS-1:0]  length;
    logic                          zero_length;

    modport source (output valid, unit_x, unit_y, unit_z, length, zero_length, input ready);
    modport sink   (input valid, unit_x, unit_y, unit_z, length, zero_length, output ready);
endinterface

`default_nettype wire

// File: rtl/vector3_normalize_core.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Modport         Beat contents
// vector    v3n_vec_if.sink    vec_x, vec_y, vec_z  (signed Q16.16)
// result    v3n_res_if.source  unit_x/y/z (Q2.30), length (Q16.16), zero_length
//
// One vector per cycle enters while the pipeline is not held; stages (CW = COMP_WIDTH, at most 32):
// capture, square, sum, one root bit per stage, one quotient bit per stage, output.
// The pipeline moves as a whole; it holds when the output register is full and not taken.
// Reset clears only the valid bits; no state carries between vectors.

module vector3_normalize_core
    import v3n_pkg::*;
#(
    parameter int COMP_WIDTH = 32
)
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    v3n_vec_if.sink    vector,
    v3n_res_if.source  result
);

    localparam int CW = (COMP_WIDTH > FIELD_BITS) ? FIELD_BITS :
                        ((COMP_WIDTH < 1) ? 1 : COMP_WIDTH);
    localparam int SW = 2 * CW + 2;
    localparam int QB = QUOT_BITS;
    localparam int NS = CW + QB + 4;

    logic          en;
    logic [NS-1:0] v_reg;

    assign en           = !v_reg[NS-1] || result.ready;
    assign vector.ready = en;
    assign result.valid = v_reg[NS-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[NS-2:0], vector.valid};
        end
    end

    // capture: split into magnitude and sign
    logic [CW-1:0]   raw_in [3];
    logic [CW-1:0]   mag_a_reg [3];
    logic [2:0]      neg_a_reg;

    assign raw_in[0] = vector.vec_x[CW-1:0];
    assign raw_in[1] = vector.vec_y[CW-1:0];
    assign raw_in[2] = vector.vec_z[CW-1:0];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int c = 0; c < 3; c++)
            begin
                neg_a_reg[c] <= raw_in[c][CW-1];
                mag_a_reg[c] <= raw_in[c][CW-1] ? (~raw_in[c] + 1'b1) : raw_in[c];
            end
        end
    end

    // square
    logic [2*CW-1:0] sq_b_reg [3];
    logic [CW-1:0]   mag_b_reg [3];
    logic [2:0]      neg_b_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int c = 0; c < 3; c++)
            begin
                sq_b_reg[c]  <= mag_a_reg[c] * mag_a_reg[c];
                mag_b_reg[c] <= mag_a_reg[c];
            end
            neg_b_reg <= neg_a_reg;
        end
    end

    // sum, into the head of the root chain
    logic [SW-1:0] rem_reg  [0:CW];
    logic [CW-1:0] root_reg [0:CW];
    logic [CW-1:0] sm_reg   [0:CW][3];
    logic [2:0]    sn_reg   [0:CW];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0]  <= SW'(sq_b_reg[0]) + SW'(sq_b_reg[1]) + SW'(sq_b_reg[2]);
            root_reg[0] <= '0;
            sm_reg[0]   <= mag_b_reg;
            sn_reg[0]   <= neg_b_reg;
        end
    end

    // square root, one result bit per stage, most significant first
    for (genvar i = 0; i < CW; i++)
    begin : g_sqrt
        localparam int K = CW - 1 - i;
        logic [SW-1:0] trial;

        assign trial = (SW'(root_reg[i]) << (K + 1)) | (SW'(1) << (2 * K));

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (rem_reg[i] >= trial)
                begin
                    rem_reg[i+1]  <= rem_reg[i] - trial;
                    root_reg[i+1] <= root_reg[i] | (CW'(1) << K);
                end
                else
                begin
                    rem_reg[i+1]  <= rem_reg[i];
                    root_reg[i+1] <= root_reg[i];
                end
                sm_reg[i+1] <= sm_reg[i];
                sn_reg[i+1] <= sn_reg[i];
            end
        end
    end

    // divide (mag << 30) by length, one quotient bit per stage
    logic [CW-1:0] dr_reg  [1:QB][3];
    logic [QB-1:0] dq_reg  [1:QB][3];
    logic [CW-1:0] len_reg [1:QB];
    logic [2:0]    dn_reg  [1:QB];

    for (genvar i = 0; i < QB; i++)
    begin : g_div
        logic [CW-1:0] r_in  [3];
        logic [QB-1:0] q_in  [3];
        logic [CW-1:0] len_in;
        logic [2:0]    neg_in;
        logic [CW:0]   r_sh  [3];
        logic [CW-1:0] r_out [3];
        logic [QB-1:0] q_out [3];

        if (i == 0)
        begin : g_first
            // mag >> 1 already sits below the divisor; mag[0] enters now
            always_comb
            begin
                for (int c = 0; c < 3; c++)
                begin
                    r_in[c] = sm_reg[CW][c] >> 1;
                    q_in[c] = '0;
                    r_sh[c] = {r_in[c], sm_reg[CW][c][0]};
                end
            end
            assign len_in = root_reg[CW];
            assign neg_in = sn_reg[CW];
        end
        else
        begin : g_rest
            always_comb
            begin
                for (int c = 0; c < 3; c++)
                begin
                    r_in[c] = dr_reg[i][c];
                    q_in[c] = dq_reg[i][c];
                    r_sh[c] = {r_in[c], 1'b0};
                end
            end
            assign len_in = len_reg[i];
            assign neg_in = dn_reg[i];
        end

        always_comb
        begin
            for (int c = 0; c < 3; c++)
            begin
                if (r_sh[c] >= {1'b0, len_in})
                begin
                    r_out[c] = CW'(r_sh[c] - {1'b0, len_in});
                    q_out[c] = {q_in[c][QB-2:0], 1'b1};
                end
                else
                begin
                    r_out[c] = r_sh[c][CW-1:0];
                    q_out[c] = {q_in[c][QB-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                dr_reg[i+1]  <= r_out;
                dq_reg[i+1]  <= q_out;
                len_reg[i+1] <= len_in;
                dn_reg[i+1]  <= neg_in;
            end
        end
    end

    // output register: restore sign, clear on zero length
    logic                         zero_next;
    logic [FIELD_BITS-1:0]        mag_out [3];
    logic signed [FIELD_BITS-1:0] unit_next [3];
    logic signed [FIELD_BITS-1:0] unit_reg [3];
    logic [FIELD_BITS-1:0]        length_reg;
    logic                         zero_reg;

    always_comb
    begin
        zero_next = (len_reg[QB] == '0);
        for (int c = 0; c < 3; c++)
        begin
            mag_out[c] = FIELD_BITS'(dq_reg[QB][c]);
            if (zero_next)
            begin
                unit_next[c] = '0;
            end
            else if (dn_reg[QB][c])
            begin
                unit_next[c] = -mag_out[c];
            end
            else
            begin
                unit_next[c] = mag_out[c];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            unit_reg   <= unit_next;
            length_reg <= FIELD_BITS'(len_reg[QB]);
            zero_reg   <= zero_next;
        end
    end

    assign result.unit_x      = unit_reg[0];
    assign result.unit_y      = unit_reg[1];
    assign result.unit_z      = unit_reg[2];
    assign result.length      = length_reg;
    assign result.zero_length = zero_reg;

    localparam logic signed [FIELD_BITS-1:0] ONE_Q30 = FIELD_BITS'(1) << UNIT_FRAC;

    a_zero_flag: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> (result.zero_length == (result.length == '0)))
        else $error("zero_length disagrees with length");

    a_zero_units: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.zero_length) |->
        (result.unit_x == '0 && result.unit_y == '0 && result.unit_z == '0))
        else $error("nonzero unit vector on zero length");

    a_unit_range: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |->
        (result.unit_x <= ONE_Q30 && result.unit_x >= -ONE_Q30 &&
         result.unit_y <= ONE_Q30 && result.unit_y >= -ONE_Q30 &&
         result.unit_z <= ONE_Q30 && result.unit_z >= -ONE_Q30))
        else $error("unit component beyond one");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(v_reg))
        else $error("pipeline moved while held");

endmodule

`default_nettype wire

// File: tb/vector3_normalize_checker.sv
`timescale 1ns / 1ps

module vector3_normalize_checker
    import v3n_pkg::*;
#(
    parameter int COMP_WIDTH = 32
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    v3n_vec_if        vector,
    v3n_res_if        result,
    output int        fail_count,
    output int        pending_count
);

    typedef struct packed {
        logic [FIELD_BITS-1:0] ux;
        logic [FIELD_BITS-1:0] uy;
        logic [FIELD_BITS-1:0] uz;
        logic [FIELD_BITS-1:0] len;
        logic                  zl;
    } unit_vec_t;

    unit_vec_t expected_units[$];

    function automatic int usable_width();
        int w;
        w = COMP_WIDTH;
        if (w < 1) w = 1;
        if (w > FIELD_BITS) w = FIELD_BITS;
        return w;
    endfunction

    function automatic logic [63:0] magnitude(input logic [FIELD_BITS-1:0] raw, output logic neg);
        int          w;
        logic [63:0] mask;
        logic [63:0] v;
        w = usable_width();
        mask = (64'd1 << w) - 1;
        v = {32'd0, raw} & mask;
        neg = v[w-1];
        if (neg) v = (~v + 1) & mask;
        return v;
    endfunction

    function automatic logic [63:0] floor_sqrt(input logic [63:0] n);
        logic [63:0] root;
        logic [63:0] trial;
        root = 0;
        for (int b = 31; b >= 0; b--) begin
            trial = root | (64'd1 << b);
            if (trial * trial <= n) root = trial;
        end
        return root;
    endfunction

    function automatic unit_vec_t normalize(input logic [FIELD_BITS-1:0] x,
                                            input logic [FIELD_BITS-1:0] y,
                                            input logic [FIELD_BITS-1:0] z);
        unit_vec_t   r;
        logic [63:0] m[3];
        logic        n[3];
        logic [63:0] sum;
        logic [63:0] len;
        logic [63:0] q[3];
        m[0] = magnitude(x, n[0]);
        m[1] = magnitude(y, n[1]);
        m[2] = magnitude(z, n[2]);
        sum = m[0] * m[0] + m[1] * m[1] + m[2] * m[2];
        len = floor_sqrt(sum);
        for (int i = 0; i < 3; i++) begin
            q[i] = (len != 0) ? (m[i] << UNIT_FRAC) / len : 64'd0;
            if (n[i]) q[i] = ~q[i] + 1;
        end
        r.ux = q[0][31:0];
        r.uy = q[1][31:0];
        r.uz = q[2][31:0];
        r.len = len[31:0];
        r.zl = (len == 0);
        return r;
    endfunction

    assign pending_count = expected_units.size();

    always @(posedge clk or negedge rst_n)
    begin
        unit_vec_t e;
        if (!rst_n)
        begin
            fail_count <= 0;
        end
        else
        begin
            if (vector.valid && vector.ready)
                expected_units.push_back(normalize(vector.vec_x, vector.vec_y, vector.vec_z));
            if (result.valid && result.ready)
            begin
                if (expected_units.size() == 0)
                begin
                    $display("%0t: result beat with nothing expected", $time);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    e = expected_units.pop_front();
                    if (e.ux !== result.unit_x || e.uy !== result.unit_y ||
                        e.uz !== result.unit_z || e.len !== result.length ||
                        e.zl !== result.zero_length)
                    begin
                        $display("%0t: expected x=%h y=%h z=%h len=%h zl=%b", $time,
                                 e.ux, e.uy, e.uz, e.len, e.zl);
                        $display("%0t: actual   x=%h y=%h z=%h len=%h zl=%b", $time,
                                 result.unit_x, result.unit_y, result.unit_z,
                                 result.length, result.zero_length);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
    end

endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import v3n_pkg::*;

    localparam int COMP_WIDTH   = 32;
    localparam int LATENCY      = COMP_WIDTH + 35;
    localparam int RANDOM_ITEMS = 680;
    localparam int CYCLE_LIMIT  = 400000;

    logic clk;
    logic rst_n;
    int   fail_count;
    int   pending_count;
    int   cycle_count;
    logic hold_off;

    v3n_vec_if vector ();
    v3n_res_if result ();

    vector3_normalize_core #(.COMP_WIDTH(COMP_WIDTH)) i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .vector (vector.sink),
        .result (result.source)
    );

    vector3_normalize_checker #(.COMP_WIDTH(COMP_WIDTH)) i_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .vector        (vector),
        .result        (result),
        .fail_count    (fail_count),
        .pending_count (pending_count)
    );

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT)
            begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    // receiver: random stalls, plus one long hold-off to back up the pipeline
    initial
    begin
        int mode;
        result.ready = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_off)
                result.ready <= 0;
            else
            begin
                if (cycle_count % 300 == 0) mode = $urandom_range(0, 2);
                case (mode)
                    0: result.ready <= 1;
                    1: result.ready <= ($urandom_range(0, 3) != 0);
                    default: result.ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    initial
    begin
        hold_off = 0;
        @(posedge rst_n);
        repeat (400) @(posedge clk);
        hold_off = 1;
        repeat (3 * LATENCY) @(posedge clk);
        hold_off = 0;
    end

    // hold the beat until taken, then open a gap or keep the burst going
    task automatic send_vector(input logic [31:0] x, input logic [31:0] y,
                               input logic [31:0] z, input int gap);
        vector.valid <= 1;
        vector.vec_x <= x;
        vector.vec_y <= y;
        vector.vec_z <= z;
        do @(posedge clk); while (!vector.ready);
        if (gap > 0)
        begin
            vector.valid <= 0;
            repeat (gap) @(posedge clk);
        end
    endtask

    function automatic logic [31:0] random_component();
        case ($urandom_range(0, 5))
            0: return $urandom_range(0, 255) - 128;
            1: return 32'h8000_0000 + $urandom_range(0, 3);
            2: return 32'h7FFF_FFFF - $urandom_range(0, 3);
            3: return $urandom() >> $urandom_range(0, 31);
            default: return $urandom();
        endcase
    endfunction

    initial
    begin
        logic [31:0] corners[10];
        int burst;
        int gap;
        corners = '{32'h0, 32'h1, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                    32'h0001_0000, 32'hFFFF_0000, 32'h5555_5555, 32'hAAAA_AAAA, 32'h3};
        rst_n = 0;
        vector.valid = 0;
        vector.vec_x = 0;
        vector.vec_y = 0;
        vector.vec_z = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // zero vector, single-axis extremes, full-scale mixes
        send_vector(0, 0, 0, 0);
        for (int i = 0; i < 10; i++)
            send_vector(corners[i], 0, 0, 0);
        send_vector(0, 32'h8000_0000, 0, 0);
        send_vector(0, 0, 32'h7FFF_FFFF, 0);
        send_vector(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1);
        send_vector(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0);
        send_vector(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 2);
        send_vector(32'h1, 32'hFFFF_FFFF, 32'h1, 0);
        send_vector(32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 0);
        send_vector(32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 0);
        send_vector(32'h0003_0000, 32'h0004_0000, 0, 0);

        burst = 0;
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (burst == 0)
            begin
                burst = $urandom_range(1, 40);
                gap = $urandom_range(1, 6);
            end
            burst--;
            if ($urandom_range(0, 19) == 0)
                send_vector(0, 0, 0, burst == 0 ? gap : 0);
            else
                send_vector(random_component(), random_component(), random_component(),
                            burst == 0 ? gap : 0);
        end
        vector.valid <= 0;

        while (pending_count != 0) @(posedge clk);
        repeat (LATENCY + 10) @(posedge clk);
        if (fail_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
